// ===== design/gyro_bias_tracking_heading_integrator_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Gyro bias tracking heading integrator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GYRO_BIAS_TRACKING_HEADING_INTEGRATOR_UNIT_DEFINES_SVH
`define GYRO_BIAS_TRACKING_HEADING_INTEGRATOR_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define GBHI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent
`define GBHI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/gbhi_pkg.sv =====
// ---------------------------------------------------------------------------
// Gyro bias tracking heading integrator: shared package
// Field widths, register reset values, limits, register codes and the
// control bundle between the top level and the window store.
// ---------------------------------------------------------------------------
package gbhi_pkg;

	// Field widths
	localparam int RATE_W     = 16;
	localparam int THR_W      = 15;
	localparam int PER_W      = 16;
	localparam int HEAD_W     = 64;
	localparam int BIAS_W     = 21;
	localparam int CORR_W     = 22;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Structure
	localparam int WINDOW_DEPTH_DEF = 32;
	localparam int PIPE_STAGES      = 7;
	localparam int FRAC_SHIFT       = 5;     // Q8.8 to Q8.13
	localparam int RATE_MAG_MAX     = 32767; // largest positive 16-bit rate

	// Register reset values
	localparam logic [THR_W-1:0] THR_RESET = 15'd256;
	localparam logic [PER_W-1:0] PER_RESET = 16'd655;

	// Saturation limits
	localparam int BIAS_MAX = 1048575;
	localparam int BIAS_MIN = -1048576;
	localparam int CORR_MAX = 2097151;
	localparam int CORR_MIN = -2097152;
	localparam int BIAS_LIM = RATE_MAG_MAX * (1 << FRAC_SHIFT);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IDLE_THRESHOLD,
		REG_SAMPLE_PERIOD
	} cfg_reg_t;

	// Control from the pipeline to the window store
	typedef struct packed {
		logic acc;     // sample transaction this cycle
		logic upd;     // accepted sample enters the window
		logic upd_s1;  // sample in stage 1 entered the window
		logic ld_s2;   // stage 1 moves into stage 2
	} win_ctrl_t;

endpackage

// ===== design/gbhi_sample_if.sv =====
// ---------------------------------------------------------------------------
// Gyro bias tracking heading integrator: sample channel
// One raw angular rate sample per transaction.
// ---------------------------------------------------------------------------
interface gbhi_sample_if;
	import gbhi_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] angular_rate;

	modport source (output valid, output angular_rate, input ready);
	modport sink (input valid, input angular_rate, output ready);
endinterface

// ===== design/gbhi_result_if.sv =====
// ---------------------------------------------------------------------------
// Gyro bias tracking heading integrator: result channel
// Heading, bias, corrected rate and window update flag per transaction.
// ---------------------------------------------------------------------------
interface gbhi_result_if;
	import gbhi_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [HEAD_W-1:0] heading;
	logic signed [BIAS_W-1:0] bias;
	logic signed [CORR_W-1:0] corrected_rate;
	logic                     bias_updated;

	modport source (output valid, output heading, output bias, output corrected_rate,
		output bias_updated, input ready);
	modport sink (input valid, input heading, input bias, input corrected_rate,
		input bias_updated, output ready);
endinterface

// ===== design/gbhi_cfg_if.sv =====
// ---------------------------------------------------------------------------
// Gyro bias tracking heading integrator: configuration write channel
// One register write per transaction: register index and write data.
// ---------------------------------------------------------------------------
interface gbhi_cfg_if;
	import gbhi_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/gbhi_window.sv =====
// ---------------------------------------------------------------------------
// Gyro bias tracking heading integrator: bias window store
// Ring of still samples in a synchronous RAM with per-entry valid bits,
// write pointer and running window sum. The old entry is read and the new
// one written in the same cycle; the sum updates on the move to stage 2.
// ---------------------------------------------------------------------------
`include "gyro_bias_tracking_heading_integrator_unit_defines.svh"

module gbhi_window #(
	parameter int WINDOW_DEPTH = gbhi_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  gbhi_pkg::win_ctrl_t                                    ctrl,
	input  logic signed [gbhi_pkg::RATE_W-1:0]                     rate,
	input  logic signed [gbhi_pkg::RATE_W-1:0]                     rate_s1,
	output logic signed [gbhi_pkg::RATE_W+$clog2(WINDOW_DEPTH)-1:0] sum
);
	import gbhi_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int SW = RATE_W + AW;
	localparam logic [AW-1:0]        WP_LAST = AW'(WINDOW_DEPTH - 1);
	localparam logic signed [SW-1:0] SUM_LIM = SW'(WINDOW_DEPTH * RATE_MAG_MAX);

	logic [RATE_W-1:0]        mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0]  vld_q;
	logic [AW-1:0]            wp_q;
	logic [RATE_W-1:0]        rd_s1;
	logic                     rd_vld_s1;
	logic signed [RATE_W-1:0] old_s1;
	logic signed [SW-1:0]     sum_q;

	// Read the oldest entry and overwrite it in the same cycle
	always_ff @(posedge clk) begin
		if (ctrl.acc) begin
			rd_s1 <= mem[wp_q];
			if (ctrl.upd) begin
				mem[wp_q] <= $unsigned(rate);
			end
		end
	end

	// Entries never written read as zero
	assign old_s1 = rd_vld_s1 ? $signed(rd_s1) : '0;

	// Advance the pointer, mark entries and update the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			wp_q      <= '0;
			rd_vld_s1 <= 1'b0;
			sum_q     <= '0;
		end else begin
			if (ctrl.acc) begin
				rd_vld_s1 <= vld_q[wp_q];
				if (ctrl.upd) begin
					vld_q[wp_q] <= 1'b1;
					wp_q        <= (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
				end
			end
			if (ctrl.ld_s2 && ctrl.upd_s1) begin
				sum_q <= sum_q - SW'(old_s1) + SW'(rate_s1);
			end
		end
	end

	assign sum = sum_q;

	`GBHI_ASSERT_NOW(a_sum_range, 1'b1, (sum_q <= SUM_LIM) && (sum_q >= -SUM_LIM), "window sum out of range")
	`GBHI_ASSERT_NEXT(a_sum_hold, ctrl.ld_s2 && !ctrl.upd_s1, $stable(sum_q), "sum moved without update")
	`GBHI_ASSERT_NOW(a_vld_grow, 1'b1, (vld_q & $past(vld_q)) == $past(vld_q), "window entry lost valid")
	`GBHI_ASSERT_NOW(a_wp_range, 1'b1, 32'(wp_q) < WINDOW_DEPTH, "write pointer past window")

endmodule

// ===== design/gyro_bias_tracking_heading_integrator_unit.sv =====
// Pipeline: 7 register stages from sample transaction to result. Throughput: one sample
// per cycle unless the result side stalls; the window RAM does its read and write
// in the accept cycle, the sum and the heading each close their loop in one register.
// Backpressure on the result fills empty stages first, then holds the sample side.
// Reset: window valid bits, pointer, sum and heading clear at once, no clearing pass;
// idle threshold returns to 256 and sample period to 655.
// ---------------------------------------------------------------------------
// Gyro bias tracking heading integrator
// Tracks gyro bias over a window of still samples, removes it from each rate
// sample and integrates the corrected rate into a saturating heading.
// ---------------------------------------------------------------------------
`include "gyro_bias_tracking_heading_integrator_unit_defines.svh"

module gyro_bias_tracking_heading_integrator_unit #(
	parameter int WINDOW_DEPTH = gbhi_pkg::WINDOW_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	gbhi_cfg_if.sink      cfg,
	gbhi_sample_if.sink   sample,
	gbhi_result_if.source result
);
	import gbhi_pkg::*;

	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int SW    = RATE_W + AW;
	localparam int MW    = SW - 1 + FRAC_SHIFT;
	localparam int INC_W = CORR_W + PER_W;
	localparam logic [MW-1:0] RECIP   = MW'((64'd1 << MW) / 64'(WINDOW_DEPTH));
	localparam logic [MW-1:0] DEPTH_M = MW'(WINDOW_DEPTH);
	localparam logic signed [MW:0]     BIAS_HI = (MW+1)'(BIAS_MAX);
	localparam logic signed [MW:0]     BIAS_LO = (MW+1)'(BIAS_MIN);
	localparam logic signed [CORR_W:0] CORR_HI = (CORR_W+1)'(CORR_MAX);
	localparam logic signed [CORR_W:0] CORR_LO = (CORR_W+1)'(CORR_MIN);
	localparam logic signed [BIAS_W-1:0] BIAS_BND = BIAS_W'(BIAS_LIM);
	localparam logic signed [HEAD_W-1:0] HEAD_MAX = {1'b0, {(HEAD_W-1){1'b1}}};
	localparam logic signed [HEAD_W-1:0] HEAD_MIN = {1'b1, {(HEAD_W-1){1'b0}}};

	// Configuration registers
	logic [THR_W-1:0] thr_q;
	logic [PER_W-1:0] per_q;

	// Stage handshake
	logic [PIPE_STAGES:1] vld_q;
	logic [PIPE_STAGES:1] rdy;
	logic [PIPE_STAGES:1] up_v;
	logic [PIPE_STAGES:1] ld;

	// Stage payload
	logic [RATE_W-1:0]        rate_mag;
	logic                     upd_in;
	win_ctrl_t                win_ctrl;
	logic signed [SW-1:0]     sum_w;
	logic [SW-1:0]            sum_abs;
	logic [MW-1:0]            mag_in;
	logic [2*MW-1:0]          recip_prod;
	logic [MW-1:0]            q0_mul;
	logic [MW-1:0]            rem;
	logic [MW-1:0]            q_fix;
	logic signed [MW:0]       bias_full;
	logic signed [CORR_W:0]   corr_full;
	logic signed [INC_W:0]    inc_full;
	logic signed [HEAD_W:0]   head_sum;

	logic signed [RATE_W-1:0] rate_s1, rate_s2, rate_s3, rate_s4;
	logic                     upd_s1, upd_s2, upd_s3, upd_s4, upd_s5, upd_s6, upd_s7;
	logic [MW-1:0]            mag_s3, q0_s3;
	logic                     neg_s3;
	logic signed [BIAS_W-1:0] bias_s4, bias_s5, bias_s6, bias_s7;
	logic signed [CORR_W-1:0] corr_s5, corr_s6, corr_s7;
	logic signed [INC_W-1:0]  inc_s6;
	logic signed [HEAD_W-1:0] heading_q;

	// Take configuration writes in any cycle
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			per_q <= PER_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_IDLE_THRESHOLD: thr_q <= cfg.data[THR_W-1:0];
				REG_SAMPLE_PERIOD:  per_q <= cfg.data[PER_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage takes new data when it is empty or drains this cycle
	always_comb begin
		rdy[PIPE_STAGES] = !vld_q[PIPE_STAGES] || result.ready;
		for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign up_v         = {vld_q[PIPE_STAGES-1:1], sample.valid};
	assign ld           = rdy & up_v;
	assign sample.ready = rdy[1];
	assign result.valid = vld_q[PIPE_STAGES];

	// Gate still samples into the window
	assign rate_mag = sample.angular_rate[RATE_W-1] ? RATE_W'(-sample.angular_rate)
	                                                : $unsigned(sample.angular_rate);
	assign upd_in   = rate_mag < RATE_W'(thr_q);

	assign win_ctrl = '{acc: ld[1], upd: upd_in, upd_s1: upd_s1, ld_s2: ld[2]};

	gbhi_window #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.rate    (sample.angular_rate),
		.rate_s1 (rate_s1),
		.sum     (sum_w)
	);

	// Mean: magnitude of sum times 32, times reciprocal of the depth
	assign sum_abs    = sum_w[SW-1] ? SW'(-sum_w) : $unsigned(sum_w);
	assign mag_in     = {sum_abs[SW-2:0], {FRAC_SHIFT{1'b0}}};
	assign recip_prod = (2*MW)'(mag_in) * (2*MW)'(RECIP);

	// Correct the quotient estimate by one, restore the sign, clamp
	assign q0_mul = q0_s3 * DEPTH_M;
	assign rem    = mag_s3 - q0_mul;
	assign q_fix  = q0_s3 + MW'(rem >= DEPTH_M);
	assign bias_full = neg_s3 ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});

	// Remove the bias from the sample in Q8.13
	assign corr_full = ((CORR_W+1)'(rate_s4) <<< FRAC_SHIFT) - (CORR_W+1)'(bias_s4);

	// Heading increment and saturating accumulate
	assign inc_full = $signed(corr_s5) * $signed({1'b0, per_q});
	assign head_sum = (HEAD_W+1)'(heading_q) + (HEAD_W+1)'(inc_s6);

	// Advance stage valid bits and the heading state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			heading_q <= '0;
		end else begin
			vld_q <= (vld_q & ~rdy) | ld;
			if (ld[7]) begin
				if (head_sum[HEAD_W] != head_sum[HEAD_W-1]) begin
					heading_q <= head_sum[HEAD_W] ? HEAD_MIN : HEAD_MAX;
				end else begin
					heading_q <= head_sum[HEAD_W-1:0];
				end
			end
		end
	end

	// Stage payload registers
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			rate_s1 <= sample.angular_rate;
			upd_s1  <= upd_in;
		end
		if (ld[2]) begin
			rate_s2 <= rate_s1;
			upd_s2  <= upd_s1;
		end
		if (ld[3]) begin
			mag_s3  <= mag_in;
			q0_s3   <= recip_prod[2*MW-1:MW];
			neg_s3  <= sum_w[SW-1];
			rate_s3 <= rate_s2;
			upd_s3  <= upd_s2;
		end
		if (ld[4]) begin
			if (bias_full > BIAS_HI) begin
				bias_s4 <= BIAS_W'(BIAS_MAX);
			end else if (bias_full < BIAS_LO) begin
				bias_s4 <= BIAS_W'(BIAS_MIN);
			end else begin
				bias_s4 <= bias_full[BIAS_W-1:0];
			end
			rate_s4 <= rate_s3;
			upd_s4  <= upd_s3;
		end
		if (ld[5]) begin
			if (corr_full > CORR_HI) begin
				corr_s5 <= CORR_W'(CORR_MAX);
			end else if (corr_full < CORR_LO) begin
				corr_s5 <= CORR_W'(CORR_MIN);
			end else begin
				corr_s5 <= corr_full[CORR_W-1:0];
			end
			bias_s5 <= bias_s4;
			upd_s5  <= upd_s4;
		end
		if (ld[6]) begin
			inc_s6  <= inc_full[INC_W-1:0];
			corr_s6 <= corr_s5;
			bias_s6 <= bias_s5;
			upd_s6  <= upd_s5;
		end
		if (ld[7]) begin
			corr_s7 <= corr_s6;
			bias_s7 <= bias_s6;
			upd_s7  <= upd_s6;
		end
	end

	// Drive the result transaction
	assign result.heading        = heading_q;
	assign result.bias           = bias_s7;
	assign result.corrected_rate = corr_s7;
	assign result.bias_updated   = upd_s7;

	`GBHI_ASSERT_NOW(a_no_stall, result.ready, sample.ready, "sample side stalled without backpressure")
	`GBHI_ASSERT_NEXT(a_head_mono, ld[7] && !inc_s6[INC_W-1], heading_q >= $past(heading_q), "heading fell on non-negative step")
	`GBHI_ASSERT_NOW(a_bias_range, vld_q[4], (bias_s4 <= BIAS_BND) && (bias_s4 >= -BIAS_BND), "bias beyond sample range")

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// Gyro bias tracking heading integrator: testbench
// Drives rate samples and register writes, predicts the heading, bias,
// corrected rate and window update flag of every sample, and checks each
// result transaction in order under random stalls on both channels.
// ---------------------------------------------------------------------------
module testbench;
	import gbhi_pkg::*;

	localparam int WIN_DEPTH      = WINDOW_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 60;
	localparam int REPORT_LIMIT   = 10;

	typedef struct {
		logic signed [HEAD_W-1:0] heading;
		logic signed [BIAS_W-1:0] bias;
		logic signed [CORR_W-1:0] corrected_rate;
		logic                     bias_updated;
	} heading_result_t;

	logic clk;
	logic arst_n;

	gbhi_cfg_if    cfg_bus ();
	gbhi_sample_if rate_bus ();
	gbhi_result_if result_bus ();

	gyro_bias_tracking_heading_integrator_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sample (rate_bus),
		.result (result_bus)
	);

	// Predictor state and register copies
	logic signed [RATE_W-1:0] still_window [WIN_DEPTH];
	longint                   still_sum;
	int                       still_ptr;
	longint                   heading_acc;
	logic [THR_W-1:0]         thr_reg;
	logic [PER_W-1:0]         per_reg;

	// Stimulus and checking bookkeeping
	logic signed [RATE_W-1:0] rate_queue [$];
	heading_result_t          pending_results [$];
	heading_result_t          want;
	int                       rates_issued;
	int                       rates_accepted;
	int                       results_seen;
	int                       failures;
	int                       stall_cycles;
	int                       send_gap;
	int                       recv_gap;
	int                       recv_hold;
	bit                       idle_enable;
	bit                       rate_fire;
	bit                       result_fire;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advance the window, bias and heading by one sample
	function automatic heading_result_t integrate_rate(logic signed [RATE_W-1:0] r);
		heading_result_t  res;
		longint           mag;
		longint           bias_v;
		longint           corr;
		longint           step;
		logic signed [64:0] acc_sum;
		mag = (r < 0) ? -longint'(r) : longint'(r);
		res.bias_updated = 1'b0;
		if (mag < longint'(thr_reg)) begin
			still_sum = still_sum - longint'(still_window[still_ptr]) + longint'(r);
			still_window[still_ptr] = r;
			still_ptr = (still_ptr + 1) % WIN_DEPTH;
			res.bias_updated = 1'b1;
		end
		bias_v = (still_sum * 32) / WIN_DEPTH;
		if (bias_v > BIAS_MAX) bias_v = BIAS_MAX;
		if (bias_v < BIAS_MIN) bias_v = BIAS_MIN;
		corr = longint'(r) * 32 - bias_v;
		if (corr > CORR_MAX) corr = CORR_MAX;
		if (corr < CORR_MIN) corr = CORR_MIN;
		step = corr * longint'(per_reg);
		acc_sum = heading_acc + step;
		// Saturate at the signed 64-bit limits
		if (acc_sum[64] != acc_sum[63]) begin
			heading_acc = acc_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end else begin
			heading_acc = acc_sum[63:0];
		end
		res.heading = heading_acc;
		res.bias = bias_v[BIAS_W-1:0];
		res.corrected_rate = corr[CORR_W-1:0];
		return res;
	endfunction

	// Mostly still samples so the window keeps moving, plus noise and edges
	function automatic logic signed [RATE_W-1:0] pick_rate();
		int mag;
		bit neg;
		neg = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				if (thr_reg == 0) return RATE_W'($urandom);
				mag = $urandom_range(0, int'(thr_reg) - 1);
			end
			6, 7: return RATE_W'($urandom);
			8: begin
				mag = int'(thr_reg) + $urandom_range(0, 2) - 1;
				if (mag < 0) mag = 0;
				if (mag > RATE_MAG_MAX) mag = RATE_MAG_MAX;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
		endcase
		return neg ? RATE_W'(-mag) : RATE_W'(mag);
	endfunction

	task automatic feed_rate(logic signed [RATE_W-1:0] r);
		rate_queue.push_back(r);
		rates_issued++;
	endtask

	// Hold until every sample is taken and every result has come back
	task automatic wait_drained();
		do @(negedge clk);
		while (rates_accepted != rates_issued || pending_results.size() != 0);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk);
		while (!cfg_bus.ready);
		case (idx)
			REG_IDLE_THRESHOLD: thr_reg = value[THR_W-1:0];
			REG_SAMPLE_PERIOD:  per_reg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] per,
		int count, bit idle_on);
		idle_enable = idle_on;
		write_register(REG_IDLE_THRESHOLD, thr);
		write_register(REG_SAMPLE_PERIOD, per);
		repeat (count) feed_rate(pick_rate());
		wait_drained();
	endtask

	// Stimulus sequence
	initial begin
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_IDLE_THRESHOLD;
		cfg_bus.data = '0;
		rate_bus.valid = 1'b0;
		rate_bus.angular_rate = '0;
		result_bus.ready = 1'b0;
		foreach (still_window[i]) still_window[i] = '0;
		still_sum = 0;
		still_ptr = 0;
		heading_acc = 0;
		thr_reg = THR_RESET;
		per_reg = PER_RESET;
		rates_issued = 0;
		rates_accepted = 0;
		results_seen = 0;
		failures = 0;
		stall_cycles = 0;
		send_gap = 0;
		recv_gap = 0;
		recv_hold = 0;
		rate_fire = 1'b0;
		result_fire = 1'b0;
		idle_enable = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset register values: threshold edges, most negative rate, bit patterns
		feed_rate(16'sh0000);
		feed_rate(16'sd255);
		feed_rate(-16'sd255);
		feed_rate(16'sd256);
		feed_rate(-16'sd256);
		feed_rate(16'sd257);
		feed_rate(16'sh7FFF);
		feed_rate(16'sh8000);
		feed_rate(16'shFFFF);
		feed_rate(16'sh0001);
		feed_rate(16'sh5555);
		feed_rate(16'shAAAA);
		feed_rate(16'sd100);
		feed_rate(-16'sd200);
		feed_rate(16'sd37);
		feed_rate(-16'sd1);
		feed_rate(16'sd254);
		feed_rate(-16'sd254);
		wait_drained();

		// Widest threshold and longest period
		run_phase(16'd32767, 16'd65535, 300, 1'b1);
		// Threshold of zero keeps the bias fixed; shortest nonzero period
		run_phase(16'd0, 16'd1, 150, 1'b1);
		// Only zero samples enter the window
		run_phase(16'd1, 16'd40000, 150, 1'b0);
		repeat (2) run_phase(CFG_DATA_W'($urandom_range(2, 4000)),
			CFG_DATA_W'($urandom_range(1, 65535)), 200, 1'b1);
		run_phase(16'd256, 16'd655, 300, 1'b1);
		// Last stretch without idling
		run_phase(CFG_DATA_W'($urandom_range(0, 32767)),
			CFG_DATA_W'($urandom_range(1, 65535)), 400, 1'b0);

		repeat (PIPE_STAGES + 4) @(posedge clk);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Sample driver: present the next queued rate once the last one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			rate_bus.valid <= 1'b0;
		end else if (!rate_bus.valid || rate_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				rate_bus.valid <= 1'b0;
			end else if (rate_queue.size() == 0) begin
				rate_bus.valid <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 7);
				rate_bus.valid <= 1'b0;
			end else begin
				rate_bus.angular_rate <= rate_queue.pop_front();
				rate_bus.valid <= 1'b1;
			end
		end
	end

	// Result ready: random stalls, plus a long hold to back up the pipeline
	always @(negedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else if (recv_hold > 0) begin
			recv_hold--;
			result_bus.ready <= 1'b0;
		end else if (result_fire && results_seen % 500 == 250) begin
			recv_hold = LONG_HOLD - 1;
			result_bus.ready <= 1'b0;
		end else if (idle_enable && recv_gap > 0) begin
			recv_gap--;
			result_bus.ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 5) == 0) begin
			recv_gap = $urandom_range(0, 7);
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	// Monitor: check results, predict accepted samples, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			rate_fire = rate_bus.valid && rate_bus.ready;
			result_fire = result_bus.valid && result_bus.ready;
			if (result_fire) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("Unexpected result transaction: heading %0d bias %0d corr %0d upd %0b",
							result_bus.heading, result_bus.bias, result_bus.corrected_rate,
							result_bus.bias_updated);
				end else begin
					want = pending_results.pop_front();
					if (result_bus.heading !== want.heading || result_bus.bias !== want.bias ||
						result_bus.corrected_rate !== want.corrected_rate ||
						result_bus.bias_updated !== want.bias_updated) begin
						failures++;
						if (failures <= REPORT_LIMIT) begin
							$display("Mismatch on result %0d:", results_seen);
							$display("  heading  exp %0d got %0d", want.heading, result_bus.heading);
							$display("  bias     exp %0d got %0d", want.bias, result_bus.bias);
							$display("  corr     exp %0d got %0d", want.corrected_rate,
								result_bus.corrected_rate);
							$display("  updated  exp %0b got %0b", want.bias_updated,
								result_bus.bias_updated);
						end
					end
				end
			end
			if (rate_fire) begin
				pending_results.push_back(integrate_rate(rate_bus.angular_rate));
				rates_accepted++;
			end
			if (rate_fire || result_fire || (cfg_bus.valid && cfg_bus.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule
